@@ rtl/core/imss_pkg.sv @@
// Shared codes, types and permission table for the IMAP session state tracker.
package imss_pkg;

    localparam int OP_W   = 3;
    localparam int COND_W = 3;
    localparam int CMD_W  = 5;
    localparam int SESS_W = 3;
    localparam int ERR_W  = 2;
    localparam int NUM_CMDS = 1 << CMD_W;

    localparam logic [OP_W-1:0] OP_GREETING = 3'd0;
    localparam logic [OP_W-1:0] OP_TAGGED   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNTAGGED = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET    = 3'd4;

    localparam logic [COND_W-1:0] COND_OK      = 3'd0;
    localparam logic [COND_W-1:0] COND_PREAUTH = 3'd3;
    localparam logic [COND_W-1:0] COND_BYE     = 3'd4;

    localparam logic [CMD_W-1:0] CMD_LOGOUT       = 5'd2;
    localparam logic [CMD_W-1:0] CMD_AUTHENTICATE = 5'd4;
    localparam logic [CMD_W-1:0] CMD_LOGIN        = 5'd5;
    localparam logic [CMD_W-1:0] CMD_SELECT       = 5'd7;
    localparam logic [CMD_W-1:0] CMD_EXAMINE      = 5'd8;
    localparam logic [CMD_W-1:0] CMD_CLOSE        = 5'd18;
    localparam logic [CMD_W-1:0] CMD_UNSELECT     = 5'd19;

    localparam logic [SESS_W-1:0] ST_DISC   = 3'd0;
    localparam logic [SESS_W-1:0] ST_NOAUTH = 3'd1;
    localparam logic [SESS_W-1:0] ST_AUTH   = 3'd2;
    localparam logic [SESS_W-1:0] ST_SEL    = 3'd3;
    localparam logic [SESS_W-1:0] ST_LOGOUT = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_STATE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SYNTAX = 2'd2;

    typedef struct packed {
        logic [SESS_W-1:0] session;
        logic [ERR_W-1:0]  err;
        logic              allowed;
    } imss_result_t;

    function automatic logic [NUM_CMDS-1:0] permit_mask(input logic [SESS_W-1:0] st);
        logic [NUM_CMDS-1:0] m;
        begin
            case (st)
                ST_NOAUTH: m = 32'h0000_003F;
                ST_AUTH:   m = 32'h0003_FFC7;
                ST_SEL:    m = 32'h0FFC_0047;
                default:   m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

@@ rtl/core/imss_decode.sv @@
// Next-state, error and permission decode for one session event.
module imss_decode
    import imss_pkg::*;
(
    input  logic [SESS_W-1:0] session,
    input  logic [OP_W-1:0]   operation,
    input  logic              is_tagged,
    input  logic              is_status,
    input  logic [COND_W-1:0] condition,
    input  logic [CMD_W-1:0]  command_code,
    output imss_result_t      result
);

    logic [NUM_CMDS-1:0] mask;

    assign mask = permit_mask(session);

    always_comb
    begin
        result.session = session;
        result.err     = ERR_NONE;
        result.allowed = 1'b0;
        case (operation)
            OP_GREETING:
            begin
                if (session != ST_DISC)
                    result.err = ERR_STATE;
                else if (is_tagged || !is_status)
                    result.err = ERR_SYNTAX;
                else if (condition == COND_OK)
                    result.session = ST_NOAUTH;
                else if (condition == COND_PREAUTH)
                    result.session = ST_AUTH;
                else if (condition == COND_BYE)
                    result.session = ST_LOGOUT;
                else
                    result.err = ERR_STATE;
            end
            OP_TAGGED:
            begin
                if (session == ST_DISC || session == ST_LOGOUT)
                    result.err = ERR_STATE;
                else if (condition == COND_BYE)
                    result.session = ST_LOGOUT;
                else if (condition == COND_OK)
                begin
                    case (command_code)
                        CMD_LOGIN, CMD_AUTHENTICATE, CMD_UNSELECT, CMD_CLOSE:
                            result.session = ST_AUTH;
                        CMD_SELECT, CMD_EXAMINE:
                            result.session = ST_SEL;
                        CMD_LOGOUT:
                            result.session = ST_LOGOUT;
                        default:
                            result.session = session;
                    endcase
                end
            end
            OP_UNTAGGED:
            begin
                if (is_status && condition == COND_BYE)
                    result.session = ST_LOGOUT;
            end
            OP_QUERY:
                result.allowed = mask[command_code];
            OP_RESET:
                result.session = ST_DISC;
            default:
                result.session = session;
        endcase
    end

endmodule

@@ rtl/core/imss_top.sv @@
// Input register stage of the IMAP session state tracker.
module imss_in_stage
    import imss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic              is_tagged,
    input  logic              is_status,
    input  logic [COND_W-1:0] condition,
    input  logic [CMD_W-1:0]  command_code,
    input  logic              advance,
    output logic              valid_q,
    output logic [OP_W-1:0]   operation_q,
    output logic              is_tagged_q,
    output logic              is_status_q,
    output logic [COND_W-1:0] condition_q,
    output logic [CMD_W-1:0]  command_code_q
);

    logic              valid_reg;
    logic              valid_next;
    logic [OP_W-1:0]   operation_reg;
    logic              is_tagged_reg;
    logic              is_status_reg;
    logic [COND_W-1:0] condition_reg;
    logic [CMD_W-1:0]  command_code_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            operation_reg    <= operation;
            is_tagged_reg    <= is_tagged;
            is_status_reg    <= is_status;
            condition_reg    <= condition;
            command_code_reg <= command_code;
        end
    end

    assign valid_q        = valid_reg;
    assign operation_q    = operation_reg;
    assign is_tagged_q    = is_tagged_reg;
    assign is_status_q    = is_status_reg;
    assign condition_q    = condition_reg;
    assign command_code_q = command_code_reg;

endmodule

@@ rtl/core/imap_session_state_tracker_top.sv @@
// Top level of the IMAP session state tracker: input register, decode, result register.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_ready, operation, is_tagged, is_status, | into block
//          | condition, command_code                              |
//  out     | out_valid, out_ready, session_now, error_code,       | out of block
//          | allowed                                              |
//
// One transfer per cycle while out_ready stays high; an event moves from the input
// register to the result register once that is free, then its output transfer follows.
// The session register updates as the event leaves the input register, so the next
// event sees it in the following cycle.
// Reset puts the session in disconnected and empties both register stages.
// out_ready low holds the result and, once the input register is full, drops in_ready.
module imap_session_state_tracker_top
    import imss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic              is_tagged,
    input  logic              is_status,
    input  logic [COND_W-1:0] condition,
    input  logic [CMD_W-1:0]  command_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SESS_W-1:0] session_now,
    output logic [ERR_W-1:0]  error_code,
    output logic              allowed
);

    logic              advance;
    logic              valid_q;
    logic [OP_W-1:0]   operation_q;
    logic              is_tagged_q;
    logic              is_status_q;
    logic [COND_W-1:0] condition_q;
    logic [CMD_W-1:0]  command_code_q;
    imss_result_t      result;

    logic [SESS_W-1:0] session_reg;
    logic [SESS_W-1:0] session_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    imss_result_t      out_reg;

    assign advance = valid_q && (!out_valid_reg || out_ready);

    imss_in_stage u_in_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .is_tagged      (is_tagged),
        .is_status      (is_status),
        .condition      (condition),
        .command_code   (command_code),
        .advance        (advance),
        .valid_q        (valid_q),
        .operation_q    (operation_q),
        .is_tagged_q    (is_tagged_q),
        .is_status_q    (is_status_q),
        .condition_q    (condition_q),
        .command_code_q (command_code_q)
    );

    imss_decode u_decode (
        .session      (session_reg),
        .operation    (operation_q),
        .is_tagged    (is_tagged_q),
        .is_status    (is_status_q),
        .condition    (condition_q),
        .command_code (command_code_q),
        .result       (result)
    );

    assign session_next   = advance ? result.session : session_reg;
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= ST_DISC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            session_reg   <= session_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign session_now = out_reg.session;
    assign error_code  = out_reg.err;
    assign allowed     = out_reg.allowed;

    a_session_range: assert property (@(posedge clk) disable iff (!rst_n)
        session_reg <= ST_LOGOUT)
        else $error("session register left the defined states");

    a_result_tracks_session: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.session == session_reg))
        else $error("result state differs from session register");

    a_allowed_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.allowed |-> out_reg.err == ERR_NONE)
        else $error("allowed flag raised together with an error");

    a_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance && operation_q == OP_RESET |=> session_reg == ST_DISC)
        else $error("session reset did not return to disconnected");

    a_no_advance_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> session_reg == $past(session_reg))
        else $error("session changed without an event");

endmodule

@@ tb/imss_tb_pkg.sv @@
// Event type, extra protocol codes and the session scoreboard for the tracker testbench.
package imss_tb_pkg;

    import imss_pkg::*;

    localparam logic [OP_W-1:0]   OP_RESERVED     = 3'd7;
    localparam logic [COND_W-1:0] COND_NO         = 3'd1;
    localparam logic [COND_W-1:0] COND_BAD        = 3'd2;
    localparam logic [COND_W-1:0] COND_RESERVED   = 3'd7;
    localparam logic [CMD_W-1:0]  CMD_CAPABILITY  = 5'd0;
    localparam logic [CMD_W-1:0]  CMD_ENABLE      = 5'd6;
    localparam logic [CMD_W-1:0]  CMD_APPEND      = 5'd17;
    localparam logic [CMD_W-1:0]  CMD_IDLE        = 5'd27;
    localparam logic [CMD_W-1:0]  CMD_OTHER_FIRST = 5'd28;
    localparam logic [CMD_W-1:0]  CMD_OTHER_LAST  = 5'd31;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              tag_bit;
        logic              status;
        logic [COND_W-1:0] cond;
        logic [CMD_W-1:0]  cmd;
    } session_evt_t;

    class session_scoreboard;

        logic [SESS_W-1:0] session;
        imss_result_t      pending_results[$];
        int                errors;
        int                transfers_in;
        int                results_checked;
        int                op_hits[8];
        int                state_hits[5];

        function new();
            session = ST_DISC;
            errors = 0;
            transfers_in = 0;
            results_checked = 0;
            foreach (op_hits[i]) op_hits[i] = 0;
            foreach (state_hits[i]) state_hits[i] = 0;
        endfunction

        function bit may_send(logic [CMD_W-1:0] cmd);
            case (session)
                ST_NOAUTH: return cmd <= CMD_LOGIN;
                ST_AUTH:   return cmd <= CMD_LOGOUT || (cmd >= CMD_ENABLE && cmd <= CMD_APPEND);
                ST_SEL:    return cmd <= CMD_LOGOUT || cmd == CMD_ENABLE ||
                                  (cmd >= CMD_CLOSE && cmd <= CMD_IDLE);
                default:   return 1'b0;
            endcase
        endfunction

        function imss_result_t next_session_result(session_evt_t e);
            imss_result_t r;
            r.err = ERR_NONE;
            r.allowed = 1'b0;
            case (e.op)
                OP_GREETING:
                begin
                    if (session != ST_DISC) r.err = ERR_STATE;
                    else if (e.tag_bit || !e.status) r.err = ERR_SYNTAX;
                    else if (e.cond == COND_OK) session = ST_NOAUTH;
                    else if (e.cond == COND_PREAUTH) session = ST_AUTH;
                    else if (e.cond == COND_BYE) session = ST_LOGOUT;
                    else r.err = ERR_STATE;
                end
                OP_TAGGED:
                begin
                    if (session == ST_DISC || session == ST_LOGOUT) r.err = ERR_STATE;
                    else if (e.cond == COND_BYE) session = ST_LOGOUT;
                    else if (e.cond == COND_OK)
                    begin
                        case (e.cmd)
                            CMD_LOGIN, CMD_AUTHENTICATE, CMD_UNSELECT, CMD_CLOSE:
                                session = ST_AUTH;
                            CMD_SELECT, CMD_EXAMINE:
                                session = ST_SEL;
                            CMD_LOGOUT:
                                session = ST_LOGOUT;
                            default:
                                ;
                        endcase
                    end
                end
                OP_UNTAGGED:
                begin
                    if (e.status && e.cond == COND_BYE) session = ST_LOGOUT;
                end
                OP_QUERY:
                    r.allowed = may_send(e.cmd);
                OP_RESET:
                    session = ST_DISC;
                default:
                    ;
            endcase
            r.session = session;
            return r;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void note_event(session_evt_t e);
            pending_results.push_back(next_session_result(e));
            transfers_in++;
            op_hits[e.op]++;
        endfunction

        task check_result(logic [SESS_W-1:0] got_session, logic [ERR_W-1:0] got_err,
                          logic got_allowed);
            imss_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result transfer with nothing outstanding (session_now %0d)",
                                 got_session));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            state_hits[want.session]++;
            if (got_session !== want.session)
                report($sformatf("result %0d: session_now %0d, want %0d",
                                 results_checked, got_session, want.session));
            if (got_err !== want.err)
                report($sformatf("result %0d: error_code %0d, want %0d",
                                 results_checked, got_err, want.err));
            if (got_allowed !== want.allowed)
                report($sformatf("result %0d: allowed %0d, want %0d",
                                 results_checked, got_allowed, want.allowed));
        endtask

        task summarize();
            $display("Run covered %0d events: greet %0d, tagged %0d, untagged %0d, %s%0d%s%0d%s%0d",
                     transfers_in, op_hits[0], op_hits[1], op_hits[2],
                     "query ", op_hits[3], ", reset ", op_hits[4], ", undefined ",
                     op_hits[5] + op_hits[6] + op_hits[7]);
            $display("Checked %0d results: disc %0d, noauth %0d, auth %0d, sel %0d, logout %0d",
                     results_checked, state_hits[0], state_hits[1], state_hits[2],
                     state_hits[3], state_hits[4]);
        endtask

    endclass

endpackage

@@ tb/testbench.sv @@
// Top-level testbench for the IMAP session state tracker: stimulus, handshakes and checking.
module testbench;

    import imss_pkg::*;
    import imss_tb_pkg::*;

    localparam int RUN_ITEMS    = 750;
    localparam int HOLD_AT      = 250;
    localparam int PAUSE_AT     = 500;
    localparam int LONG_HOLD    = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   operation = '0;
    logic              is_tagged = 1'b0;
    logic              is_status = 1'b0;
    logic [COND_W-1:0] condition = '0;
    logic [CMD_W-1:0]  command_code = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SESS_W-1:0] session_now;
    logic [ERR_W-1:0]  error_code;
    logic              allowed;

    session_scoreboard sb;
    int                sent = 0;
    int                no_gap_left = 0;
    bit                send_quiet = 1'b0;
    bit                hold_request = 1'b0;
    int                idle_cycles = 0;

    imap_session_state_tracker_top i_dut (.*);

    always #10 clk = ~clk;

    function automatic session_evt_t mk(logic [OP_W-1:0] op, logic tag_bit, logic status,
                                        logic [COND_W-1:0] cond, logic [CMD_W-1:0] cmd);
        session_evt_t e;
        e.op = op;
        e.tag_bit = tag_bit;
        e.status = status;
        e.cond = cond;
        e.cmd = cmd;
        return e;
    endfunction

    function automatic session_evt_t any_event();
        return mk(OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), COND_W'($urandom_range(0, 7)),
                  CMD_W'($urandom_range(0, 31)));
    endfunction

    function automatic logic [CMD_W-1:0] pick_key_cmd();
        case ($urandom_range(0, 7))
            0:       return CMD_LOGIN;
            1:       return CMD_AUTHENTICATE;
            2:       return CMD_SELECT;
            3:       return CMD_EXAMINE;
            4:       return CMD_CLOSE;
            5:       return CMD_UNSELECT;
            6:       return CMD_LOGOUT;
            default: return CMD_W'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic send_event(session_evt_t e);
        int gap;
        gap = (send_quiet || no_gap_left > 0) ? 0 : $urandom_range(0, 18);
        if (no_gap_left > 0) no_gap_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= e.op;
        is_tagged    <= e.tag_bit;
        is_status    <= e.status;
        condition    <= e.cond;
        command_code <= e.cmd;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (sent % 60 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // reset, greeting, then a run of events with random content
    task automatic run_session();
        session_evt_t e;
        int           steps;
        int           r;
        e = any_event();
        e.op = OP_RESET;
        send_event(e);
        e = any_event();
        e.op = OP_GREETING;
        if ($urandom_range(0, 99) < 85)
        begin
            e.tag_bit = 1'b0;
            e.status = 1'b1;
            e.cond = ($urandom_range(0, 3) == 0) ? COND_PREAUTH : COND_OK;
        end
        send_event(e);
        steps = $urandom_range(2, 14);
        repeat (steps)
        begin
            r = $urandom_range(0, 99);
            e = any_event();
            if (r < 40)
            begin
                e.op = OP_TAGGED;
                if ($urandom_range(0, 4) != 0) e.cond = COND_OK;
                if ($urandom_range(0, 4) < 3) e.cmd = pick_key_cmd();
            end
            else if (r < 70)
                e.op = OP_QUERY;
            else if (r < 80)
            begin
                e.op = OP_UNTAGGED;
                if ($urandom_range(0, 3) == 0) e.cond = COND_BYE;
            end
            else if (r < 90)
                e.op = OP_GREETING;
            send_event(e);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_event(mk(operation, is_tagged, is_status, condition, command_code));
        if (rst_n && out_valid && out_ready)
            sb.check_result(session_now, error_code, allowed);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, 18);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (taken % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(mk(OP_QUERY, 1'b0, 1'b0, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_LOGIN));
        send_event(mk(OP_GREETING, 1'b1, 1'b1, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_GREETING, 1'b0, 1'b0, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_GREETING, 1'b0, 1'b1, COND_NO, CMD_CAPABILITY));
        send_event(mk(OP_GREETING, 1'b0, 1'b1, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_GREETING, 1'b0, 1'b1, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_QUERY, 1'b0, 1'b0, COND_OK, CMD_LOGIN));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_BAD, CMD_LOGIN));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_LOGIN));
        send_event(mk(OP_QUERY, 1'b0, 1'b0, COND_OK, CMD_CLOSE));
        send_event(mk(OP_TAGGED, 1'b1, 1'b1, COND_OK, CMD_SELECT));
        send_event(mk(OP_QUERY, 1'b0, 1'b0, COND_OK, CMD_IDLE));
        send_event(mk(OP_QUERY, 1'b0, 1'b0, COND_OK, CMD_OTHER_FIRST));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_CLOSE));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_EXAMINE));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_RESERVED, CMD_UNSELECT));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_UNSELECT));
        send_event(mk(OP_UNTAGGED, 1'b0, 1'b0, COND_BYE, CMD_CAPABILITY));
        send_event(mk(OP_RESERVED, 1'b1, 1'b1, COND_RESERVED, CMD_OTHER_LAST));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_LOGOUT));
        send_event(mk(OP_TAGGED, 1'b0, 1'b0, COND_OK, CMD_LOGIN));
        send_event(mk(OP_RESET, 1'b1, 1'b1, COND_RESERVED, CMD_OTHER_LAST));
        send_event(mk(OP_GREETING, 1'b0, 1'b1, COND_PREAUTH, CMD_CAPABILITY));
        send_event(mk(OP_UNTAGGED, 1'b0, 1'b1, COND_BYE, CMD_CAPABILITY));
        send_event(mk(OP_RESET, 1'b0, 1'b0, COND_OK, CMD_CAPABILITY));
        send_event(mk(OP_GREETING, 1'b0, 1'b1, COND_BYE, CMD_CAPABILITY));

        while (sent < RUN_ITEMS)
        begin
            if (!hold_done && sent >= HOLD_AT)
            begin
                hold_request = 1'b1;
                no_gap_left = 40;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= PAUSE_AT)
            begin
                drain_outputs();
                pause_done = 1'b1;
            end
            run_session();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.summarize();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
